// ----- hdl/fyse_pkg.sv -----
// Shared types and constants for the Fisher-Yates shuffle engine.
// No dependencies.
package fyse_pkg;

  localparam int MAX_LENGTH_DEF = 1024;
  localparam int LEN_W          = 11;
  localparam int POS_W          = 10;
  localparam int WORD_W         = 64;
  localparam int M_TDATA_W      = 24;
  localparam int EPOCH_W        = 8;
  localparam int Q_DEPTH        = 8;
  localparam int Q_AW           = 3;
  localparam int Q_CW           = 4;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_ONE,
    ST_SWAP
  } stage_kind_t;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] value;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

// ----- hdl/fyse_table.sv -----
// Permutation table: one write port, two registered read ports.
// Each entry holds an epoch tag and a value. Depends on nothing.
module fyse_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 18
) (
  input  logic          clk,
  input  logic [AW-1:0] ra,
  input  logic [AW-1:0] rb,
  output logic [DW-1:0] rd_a,
  output logic [DW-1:0] rd_b,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rd_a <= mem[ra];
    rd_b <= mem[rb];
    if (we) begin
      mem[wa] <= wd;
    end
  end

endmodule

// ----- hdl/fyse_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one.
// Depends on fyse_pkg.
module fyse_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  fyse_pkg::push_t           push,
  output logic                      room,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [fyse_pkg::M_TDATA_W-1:0] m_tdata,  // position[9:0], value[19:10], zero pad
  output logic                      m_tlast
);

  fyse_pkg::result_t           q [fyse_pkg::Q_DEPTH];
  logic [fyse_pkg::Q_AW-1:0]   wp;
  logic [fyse_pkg::Q_AW-1:0]   rp;
  logic [fyse_pkg::Q_CW-1:0]   count;
  logic                        pop;
  fyse_pkg::result_t           head;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = q[rp];
  assign m_tdata  = fyse_pkg::M_TDATA_W'({head.value, head.position});
  assign m_tlast  = head.last;
  assign room     = (count <= fyse_pkg::Q_CW'(fyse_pkg::Q_DEPTH - 4));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + fyse_pkg::Q_AW'(push.v0) + fyse_pkg::Q_AW'(push.v1);
      rp    <= rp + fyse_pkg::Q_AW'(pop);
      count <= count + fyse_pkg::Q_CW'(push.v0) + fyse_pkg::Q_CW'(push.v1)
               - fyse_pkg::Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q[wp] <= push.r0;
    end
    if (push.v1) begin
      q[wp + fyse_pkg::Q_AW'(1)] <= push.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= fyse_pkg::Q_CW'(fyse_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second result pushed without first");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wp - rp) == fyse_pkg::Q_AW'(count))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- hdl/fyse_core.sv -----
// Shuffle control: cursor, draw and accept, swap stage with forwarding,
// epoch tags and the tag sweep. Depends on fyse_pkg.
module fyse_core #(
  parameter int MAX_LENGTH = fyse_pkg::MAX_LENGTH_DEF,
  parameter int AW         = $clog2(MAX_LENGTH),
  parameter int DW         = fyse_pkg::EPOCH_W + AW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fyse_pkg::LEN_W-1:0]    cfg_len,
  input  logic                          in_valid,
  input  logic                          in_op,
  input  logic [fyse_pkg::WORD_W-1:0]   in_word,
  output logic                          in_ready,
  input  logic                          q_room,
  output fyse_pkg::push_t               push,
  output logic [AW-1:0]                 ra,
  output logic [AW-1:0]                 rb,
  input  logic [DW-1:0]                 rd_a,
  input  logic [DW-1:0]                 rd_b,
  output logic                          we,
  output logic [AW-1:0]                 wa,
  output logic [DW-1:0]                 wd
);

  localparam int EW = fyse_pkg::EPOCH_W;
  localparam logic [AW-1:0] CUR_MAX   = AW'(MAX_LENGTH - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);
  localparam logic [EW-1:0] EPOCH_TOP = '1;

  logic [fyse_pkg::LEN_W-1:0] perm_length;
  logic [AW-1:0]              cursor;
  logic                       active;
  logic [EW-1:0]              epoch;
  logic                       clearing;
  logic [AW-1:0]              clr_addr;
  logic                       fwd_valid;
  logic [AW-1:0]              fwd_addr;
  logic [AW-1:0]              fwd_val;

  fyse_pkg::stage_kind_t      s1_kind;
  logic [AW-1:0]              s1_cur;
  logic [AW-1:0]              s1_r;
  logic                       s1_fin;

  logic                       accept;
  logic [AW-1:0]              mask;
  logic [AW-1:0]              draw;
  logic                       hit;
  logic                       len_one;
  logic [AW-1:0]              begin_cur;
  logic [AW-1:0]              b_addr;
  logic [AW-1:0]              val_a;
  logic [AW-1:0]              val_b;
  logic                       swap_we;

  function automatic logic [AW-1:0] entry(
    input logic [AW-1:0] addr,
    input logic [DW-1:0] rd,
    input logic          fv,
    input logic [AW-1:0] fa,
    input logic [AW-1:0] fval,
    input logic [EW-1:0] ep
  );
    logic [AW-1:0] res;
    if (fv && (fa == addr)) begin
      res = fval;
    end else if (rd[DW-1:AW] == ep) begin
      res = rd[AW-1:0];
    end else begin
      res = addr;
    end
    return res;
  endfunction

  assign in_ready = !clearing && q_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = |(cursor >> i);
    end
  end

  assign draw    = in_word[AW-1:0] & mask;
  assign hit     = active && (draw <= cursor);
  assign len_one = (perm_length <= fyse_pkg::LEN_W'(1));

  always_comb begin
    if (32'(perm_length) > 32'(MAX_LENGTH)) begin
      begin_cur = CUR_MAX;
    end else if (len_one) begin
      begin_cur = '0;
    end else begin
      begin_cur = AW'(perm_length - fyse_pkg::LEN_W'(1));
    end
  end

  // at the last step port B fetches entry 0 for the closing result
  assign ra = cursor;
  assign rb = (cursor == AW'(1)) ? '0 : draw;

  assign b_addr = s1_fin ? '0 : s1_r;
  assign val_a  = entry(s1_cur, rd_a, fwd_valid, fwd_addr, fwd_val, epoch);
  assign val_b  = entry(b_addr, rd_b, fwd_valid, fwd_addr, fwd_val, epoch);

  assign swap_we = (s1_kind == fyse_pkg::ST_SWAP) && !s1_fin;

  always_comb begin
    we = 1'b0;
    wa = s1_r;
    wd = {epoch, val_a};
    if (clearing) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (swap_we) begin
      we = 1'b1;
    end
  end

  always_comb begin
    push = '0;
    case (s1_kind)
      fyse_pkg::ST_ONE: begin
        push.v0          = 1'b1;
        push.r0.last     = 1'b1;
      end
      fyse_pkg::ST_SWAP: begin
        push.v0          = 1'b1;
        push.r0.position = fyse_pkg::POS_W'(s1_cur);
        if (s1_fin) begin
          push.v1          = 1'b1;
          push.r0.value    = fyse_pkg::POS_W'((s1_r == '0) ? val_b : val_a);
          push.r1.value    = fyse_pkg::POS_W'((s1_r == '0) ? val_a : val_b);
          push.r1.last     = 1'b1;
        end else begin
          push.r0.value    = fyse_pkg::POS_W'(val_b);
        end
      end
      default: begin
        push = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= fyse_pkg::LEN_W'(1);
      cursor      <= '0;
      active      <= 1'b0;
      epoch       <= EW'(1);
      clearing    <= 1'b1;
      clr_addr    <= '0;
      fwd_valid   <= 1'b0;
      s1_kind     <= fyse_pkg::ST_NONE;
    end else begin
      if (cfg_we) begin
        perm_length <= cfg_len;
      end
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      if (swap_we) begin
        fwd_valid <= 1'b1;
      end
      s1_kind <= fyse_pkg::ST_NONE;
      if (accept) begin
        if (in_op == fyse_pkg::OP_BEGIN) begin
          cursor    <= begin_cur;
          active    <= !len_one;
          fwd_valid <= 1'b0;
          if (len_one) begin
            s1_kind <= fyse_pkg::ST_ONE;
          end
          if (epoch == EPOCH_TOP) begin
            epoch    <= EW'(1);
            clearing <= 1'b1;
            clr_addr <= '0;
          end else begin
            epoch <= epoch + EW'(1);
          end
        end else if (hit) begin
          s1_kind <= fyse_pkg::ST_SWAP;
          cursor  <= cursor - AW'(1);
          if (cursor == AW'(1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (swap_we) begin
      fwd_addr <= s1_r;
      fwd_val  <= val_a;
    end
    if (accept) begin
      s1_cur <= cursor;
      s1_r   <= draw;
      s1_fin <= (cursor == AW'(1));
    end
  end

`ifndef NO_ASSERTIONS
  a_active_cursor: assert property (@(posedge clk) disable iff (rst)
    active |-> (cursor != '0))
    else $error("active with cursor at zero");

  a_draw_bound: assert property (@(posedge clk) disable iff (rst)
    (s1_kind == fyse_pkg::ST_SWAP) |-> (s1_r <= s1_cur))
    else $error("swap partner above cursor");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_kind == fyse_pkg::ST_SWAP) && s1_fin |-> !active)
    else $error("final swap left the engine active");

  a_sweep_fwd: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !fwd_valid)
    else $error("forwarding entry live during tag sweep");
`endif

endmodule

// ----- hdl/fisher_yates_shuffle_engine_top.sv -----
// Fisher-Yates shuffle engine, top level.
// Depends on fyse_pkg, fyse_core, fyse_table and fyse_outq.
//
// Builds a random permutation of 0..perm_length-1 by the downward shuffle with
// masked rejection draws. A transfer with tuser 0 begins a permutation; each
// transfer with tuser 1 supplies a 64-bit random word and, unless rejected,
// yields the element now final at the cursor (the last step also yields
// position 0 with tlast). One input transfer is taken per cycle while the
// result queue has room; each result is registered in the swap stage and then
// in the result queue. The table holds an epoch tag per entry so a begin costs
// no time, but after reset, and on every 255th begin when the tag wraps, a sweep
// rewrites all MAX_LENGTH tags and holds s_tready low. perm_length is taken on
// the cfg channel at any time and used at the next begin.
module fisher_yates_shuffle_engine_top #(
  parameter int MAX_LENGTH = fyse_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fyse_pkg::LEN_W-1:0]    cfg_data,   // perm_length
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fyse_pkg::WORD_W-1:0]   s_tdata,    // rand_word[63:0]
  input  logic                          s_tuser,    // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fyse_pkg::M_TDATA_W-1:0] m_tdata,   // position[9:0], value[19:10]
  output logic                          m_tlast
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int DW = fyse_pkg::EPOCH_W + AW;

  logic            q_room;
  fyse_pkg::push_t push;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   rb;
  logic [DW-1:0]   rd_a;
  logic [DW-1:0]   rd_b;
  logic            we;
  logic [AW-1:0]   wa;
  logic [DW-1:0]   wd;

  assign cfg_ready = 1'b1;

  fyse_core #(
    .MAX_LENGTH (MAX_LENGTH),
    .AW         (AW),
    .DW         (DW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_len  (cfg_data),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_word  (s_tdata),
    .in_ready (s_tready),
    .q_room   (q_room),
    .push     (push),
    .ra       (ra),
    .rb       (rb),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .we       (we),
    .wa       (wa),
    .wd       (wd)
  );

  fyse_table #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk  (clk),
    .ra   (ra),
    .rb   (rb),
    .rd_a (rd_a),
    .rd_b (rd_b),
    .we   (we),
    .wa   (wa),
    .wd   (wd)
  );

  fyse_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (q_room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- verif/fisher_yates_shuffle_engine_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fisher_yates_shuffle_engine_top: directed and random
// permutations under varied back-pressure, checked by an in-bench shuffle predictor.
// Depends on fyse_pkg and the engine RTL.
module fisher_yates_shuffle_engine_top_tb;

  localparam int PERM_MAX = fyse_pkg::MAX_LENGTH_DEF;

  typedef struct {
    logic                        op;
    logic [fyse_pkg::WORD_W-1:0] word;
  } shuffle_req_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fyse_pkg::LEN_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [fyse_pkg::WORD_W-1:0]    s_tdata = '0;    // rand_word[63:0]
  logic                           s_tuser = 1'b0;  // op
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [fyse_pkg::M_TDATA_W-1:0] m_tdata;         // position[9:0], value[19:10]
  logic                           m_tlast;

  // predictor state
  logic [fyse_pkg::POS_W-1:0] perm_tab [PERM_MAX];
  bit                         perm_mark [PERM_MAX];
  logic [fyse_pkg::POS_W-1:0] perm_cur = '0;
  bit                         perm_busy = 1'b0;
  logic [fyse_pkg::LEN_W-1:0] perm_len_reg = fyse_pkg::LEN_W'(1);

  fyse_pkg::result_t due_results[$];
  shuffle_req_t      feed_q[$];
  shuffle_req_t      feed_req;
  fyse_pkg::result_t want;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_mode = 0;
  int n_queued = 0;
  int n_begins = 0;
  int n_words = 0;
  int n_results = 0;
  int n_errors = 0;

  fisher_yates_shuffle_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [fyse_pkg::POS_W-1:0] span_mask(
    input logic [fyse_pkg::POS_W-1:0] v
  );
    logic [fyse_pkg::POS_W-1:0] m;
    for (int i = 0; i < fyse_pkg::POS_W; i++) m[i] = |(v >> i);
    return m;
  endfunction

  function automatic logic [fyse_pkg::POS_W-1:0] tab_read(input int idx);
    return perm_mark[idx] ? perm_tab[idx] : fyse_pkg::POS_W'(idx);
  endfunction

  function automatic void tab_write(input int idx, input logic [fyse_pkg::POS_W-1:0] v);
    perm_tab[idx] = v;
    perm_mark[idx] = 1'b1;
  endfunction

  function automatic void note_result(input logic [fyse_pkg::POS_W-1:0] pos,
                                      input logic [fyse_pkg::POS_W-1:0] val,
                                      input logic lst);
    fyse_pkg::result_t r;
    r.position = pos;
    r.value = val;
    r.last = lst;
    due_results.push_back(r);
  endfunction

  function automatic void shuffle_predict(input logic op,
                                          input logic [fyse_pkg::WORD_W-1:0] word);
    int unsigned                len;
    logic [fyse_pkg::POS_W-1:0] pick, a, b;
    if (op == fyse_pkg::OP_BEGIN) begin
      len = perm_len_reg;
      if (len == 0) len = 1;
      if (len > PERM_MAX) len = PERM_MAX;
      foreach (perm_mark[i]) perm_mark[i] = 1'b0;
      perm_cur = fyse_pkg::POS_W'(len - 1);
      perm_busy = (len > 1);
      if (len == 1) note_result('0, '0, 1'b1);
    end else if (perm_busy) begin
      pick = word[fyse_pkg::POS_W-1:0] & span_mask(perm_cur);
      if (pick <= perm_cur) begin
        a = tab_read(perm_cur);
        b = tab_read(pick);
        tab_write(perm_cur, b);
        tab_write(pick, a);
        note_result(perm_cur, b, 1'b0);
        perm_cur = perm_cur - 1'b1;
        if (perm_cur == 0) begin
          perm_busy = 1'b0;
          note_result('0, tab_read(0), 1'b1);
        end
      end
    end
  endfunction

  function automatic logic [fyse_pkg::WORD_W-1:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // idling pattern rotates every 150 queued items
  task automatic push_item(input logic op, input logic [fyse_pkg::WORD_W-1:0] word);
    shuffle_req_t r;
    r.op = op;
    r.word = word;
    feed_q.push_back(r);
    n_queued++;
    if (n_queued % 150 == 0) begin
      while (feed_q.size() != 0) @(posedge clk);
      idle_mode = (idle_mode + 1) % 4;
      case (idle_mode)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
      endcase
    end
  endtask

  task automatic wait_quiet();
    while (feed_q.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [fyse_pkg::LEN_W-1:0] v);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    perm_len_reg = v;
  endtask

  // begin plus words steered mostly towards acceptance; may stop early to abandon
  task automatic run_perm(input bit abandon);
    int unsigned                 eff, stop;
    logic [fyse_pkg::POS_W-1:0]  cur, r;
    logic [fyse_pkg::WORD_W-1:0] w;
    eff = perm_len_reg;
    if (eff == 0) eff = 1;
    if (eff > PERM_MAX) eff = PERM_MAX;
    cur = fyse_pkg::POS_W'(eff - 1);
    stop = abandon ? $urandom_range(0, (eff > 40) ? 40 : eff - 1) : eff;
    push_item(fyse_pkg::OP_BEGIN, rand_word64());
    while (cur != 0 && stop != 0) begin
      if ($urandom_range(0, 99) < 80) r = fyse_pkg::POS_W'($urandom_range(0, cur));
      else r = fyse_pkg::POS_W'($urandom);
      w = rand_word64();
      w[fyse_pkg::POS_W-1:0] = r;
      push_item(fyse_pkg::OP_WORD, w);
      if ((r & span_mask(cur)) <= cur) begin
        cur--;
        stop--;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        shuffle_predict(s_tuser, s_tdata);
        if (s_tuser == fyse_pkg::OP_BEGIN) n_begins++;
        else n_words++;
      end
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          feed_req = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= feed_req.op;
          s_tdata  <= feed_req.word;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 50)
          $display("%0t: unexpected transfer: position %0d value %0d last %0b", $time,
                   m_tdata[fyse_pkg::POS_W-1:0],
                   m_tdata[2*fyse_pkg::POS_W-1:fyse_pkg::POS_W], m_tlast);
      end else begin
        want = due_results.pop_front();
        if (m_tdata[fyse_pkg::POS_W-1:0] !== want.position ||
            m_tdata[2*fyse_pkg::POS_W-1:fyse_pkg::POS_W] !== want.value ||
            m_tlast !== want.last) begin
          n_errors++;
          if (n_errors <= 50)
            $display({"%0t: mismatch: expected pos %0d val %0d last %0b, ",
                      "got pos %0d val %0d last %0b"},
                     $time, want.position, want.value, want.last,
                     m_tdata[fyse_pkg::POS_W-1:0],
                     m_tdata[2*fyse_pkg::POS_W-1:fyse_pkg::POS_W], m_tlast);
        end
      end
    end
  end

  initial begin
    int unsigned len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    push_item(fyse_pkg::OP_WORD, '1);
    push_item(fyse_pkg::OP_BEGIN, '0);
    write_length(fyse_pkg::LEN_W'(0));
    push_item(fyse_pkg::OP_BEGIN, '1);
    write_length(fyse_pkg::LEN_W'(2));
    push_item(fyse_pkg::OP_BEGIN, '0);
    push_item(fyse_pkg::OP_WORD, '0);
    write_length(fyse_pkg::LEN_W'(3));
    push_item(fyse_pkg::OP_BEGIN, '0);
    push_item(fyse_pkg::OP_WORD, '1);                          // masked to 3, rejected
    push_item(fyse_pkg::OP_WORD, 64'h2);                       // partner equals cursor
    push_item(fyse_pkg::OP_BEGIN, '0);                         // abandons the running one
    push_item(fyse_pkg::OP_WORD, 64'hFFFF_FFFF_FFFF_FFFD);
    push_item(fyse_pkg::OP_WORD, 64'h5555_5555_5555_5555);
    push_item(fyse_pkg::OP_WORD, 64'hAAAA_AAAA_AAAA_AAAA);     // idle, ignored
    write_length(fyse_pkg::LEN_W'(2047));                      // saturates
    push_item(fyse_pkg::OP_BEGIN, '0);
    push_item(fyse_pkg::OP_WORD, '1);
    push_item(fyse_pkg::OP_WORD, 64'h8000_0000_0000_0000);
    write_length(fyse_pkg::LEN_W'(1024));

    // one full permutation at the largest size
    run_perm(1'b0);

    // many cheap begins, enough to wrap the table's epoch tag
    write_length(fyse_pkg::LEN_W'(1));
    repeat (130) begin
      if ($urandom_range(0, 7) == 0) push_item(fyse_pkg::OP_WORD, rand_word64());
      push_item(fyse_pkg::OP_BEGIN, rand_word64());
    end
    write_length(fyse_pkg::LEN_W'(0));
    repeat (150) push_item(fyse_pkg::OP_BEGIN, rand_word64());

    // mostly small permutations, some abandoned
    while (n_queued < 1600) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(1025, 2047);
        1, 2:    len = $urandom_range(17, 64);
        default: len = $urandom_range(2, 16);
      endcase
      write_length(fyse_pkg::LEN_W'(len));
      repeat ($urandom_range(1, 4)) begin
        run_perm(len > 64 || $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) push_item(fyse_pkg::OP_WORD, rand_word64());
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    $display("summary: %0d begins, %0d words, %0d result transfers checked, %0d errors",
             n_begins, n_words, n_results, n_errors);
    $display("summary: lengths 0 to 2047 incl. a full 1024-element shuffle, four idling patterns");
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
